FILE: rtl/core/epwr_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// Elite pool package
// Shared widths, reset values and the controller state encoding.
// ============================================================================
package epwr_pkg;

    localparam int COST_W         = 31;
    localparam int CAP_W          = 5;
    localparam int SLOT_OUT_W     = 4;
    localparam int COUNT_OUT_W    = 5;
    localparam int POOL_DEPTH_DEF = 16;
    localparam int TAG_BITS_DEF   = 16;

    localparam logic [CAP_W-1:0]  CAP_RESET     = 5'd16;
    localparam logic [COST_W-1:0] COST_ALL_ONES = {COST_W{1'b1}};

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

endpackage

FILE: rtl/core/elite_pool_worst_replacement.sv
`timescale 1ns / 1ps
// ============================================================================
// Elite pool with worst-entry replacement
// Bounded pool of minimum-cost candidates; a full pool replaces its worst entry with a strictly better offer.
// ============================================================================
// A rejected offer goes from acceptance to the finish state and then to the
// output register; an admitted offer first runs the scan wave that walks
// the row of slot cells one cell per cycle to find the first maximum and the
// minimum. One offer is in work at a time; a finished result waits in the
// output register while the next offer is accepted.
// Reset (synchronous, active low) empties the pool and sets capacity to 16.
module elite_pool_worst_replacement #(
    parameter int POOL_DEPTH = epwr_pkg::POOL_DEPTH_DEF,
    parameter int TAG_BITS   = epwr_pkg::TAG_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [epwr_pkg::CAP_W-1:0]       i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [epwr_pkg::COST_W-1:0]      i_offer_cost,
    input  logic [TAG_BITS-1:0]              i_solution_tag,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_admitted,
    output logic [epwr_pkg::SLOT_OUT_W-1:0]  o_written_slot,
    output logic                             o_evicted,
    output logic [TAG_BITS-1:0]              o_evicted_tag,
    output logic [epwr_pkg::COUNT_OUT_W-1:0] o_entry_count,
    output logic [epwr_pkg::COST_W-1:0]      o_best_cost,
    output logic [epwr_pkg::COST_W-1:0]      o_worst_cost
);

    localparam int IW = $clog2(POOL_DEPTH);
    localparam int CW = $clog2(POOL_DEPTH + 1);
    localparam int MW = (CW > epwr_pkg::CAP_W) ? CW : epwr_pkg::CAP_W;

    epwr_pkg::t_state r_state;

    logic [epwr_pkg::CAP_W-1:0]  r_cap;
    logic [CW-1:0]               r_count;
    logic [IW-1:0]               r_worst_idx;
    logic [epwr_pkg::COST_W-1:0] r_worst_cost;
    logic [TAG_BITS-1:0]         r_worst_tag;
    logic [epwr_pkg::COST_W-1:0] r_best;
    logic                        r_seed;

    logic                        r_adm;
    logic [IW-1:0]               r_slot;
    logic                        r_evict;
    logic [TAG_BITS-1:0]         r_evtag;

    logic                             r_out_valid;
    logic                             r_o_admitted;
    logic [epwr_pkg::SLOT_OUT_W-1:0]  r_o_slot;
    logic                             r_o_evicted;
    logic [TAG_BITS-1:0]              r_o_evtag;
    logic [epwr_pkg::COUNT_OUT_W-1:0] r_o_count;
    logic [epwr_pkg::COST_W-1:0]      r_o_best;
    logic [epwr_pkg::COST_W-1:0]      r_o_worst;

    logic          in_acc;
    logic          room;
    logic          replace;
    logic          wr_en;
    logic [IW-1:0] wr_idx;
    logic          out_free;

    logic                        c_valid    [POOL_DEPTH+1];
    logic [epwr_pkg::COST_W-1:0] c_max_cost [POOL_DEPTH+1];
    logic [IW-1:0]               c_max_idx  [POOL_DEPTH+1];
    logic [TAG_BITS-1:0]         c_max_tag  [POOL_DEPTH+1];
    logic [epwr_pkg::COST_W-1:0] c_min_cost [POOL_DEPTH+1];

    assign o_stall  = (r_state != epwr_pkg::S_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        room = (MW'(r_count) < MW'(r_cap)) && (MW'(r_count) < MW'(POOL_DEPTH));
        // A full pool only takes an offer that strictly beats the worst entry.
        replace = !room && (r_count != '0) && (i_offer_cost < r_worst_cost);
        wr_en   = in_acc && (room || replace);
        wr_idx  = room ? IW'(r_count) : r_worst_idx;
    end

    // Scan seed enters the first cell.
    assign c_valid[0]    = r_seed;
    assign c_max_cost[0] = '0;
    assign c_max_idx[0]  = '0;
    assign c_max_tag[0]  = '0;
    assign c_min_cost[0] = epwr_pkg::COST_ALL_ONES;

    for (genvar g = 0; g < POOL_DEPTH; g++) begin : g_cell
        epwr_cell #(
            .POOL_DEPTH (POOL_DEPTH),
            .TAG_BITS   (TAG_BITS),
            .CELL_IDX   (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_count      (r_count),
            .i_wr_en      (wr_en),
            .i_wr_idx     (wr_idx),
            .i_wr_cost    (i_offer_cost),
            .i_wr_tag     (i_solution_tag),
            .i_c_valid    (c_valid[g]),
            .i_c_max_cost (c_max_cost[g]),
            .i_c_max_idx  (c_max_idx[g]),
            .i_c_max_tag  (c_max_tag[g]),
            .i_c_min_cost (c_min_cost[g]),
            .o_c_valid    (c_valid[g+1]),
            .o_c_max_cost (c_max_cost[g+1]),
            .o_c_max_idx  (c_max_idx[g+1]),
            .o_c_max_tag  (c_max_tag[g+1]),
            .o_c_min_cost (c_min_cost[g+1])
        );
    end

    // Per-transaction result fields; the scan fills in best and worst later.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_adm   <= room || replace;
            r_slot  <= (room || replace) ? wr_idx : '0;
            r_evict <= replace;
            r_evtag <= replace ? r_worst_tag : '0;
        end
        if (r_state == epwr_pkg::S_FINISH && out_free) begin
            r_o_admitted <= r_adm;
            r_o_slot     <= epwr_pkg::SLOT_OUT_W'(r_slot);
            r_o_evicted  <= r_evict;
            r_o_evtag    <= r_evtag;
            r_o_count    <= epwr_pkg::COUNT_OUT_W'(r_count);
            r_o_best     <= r_best;
            r_o_worst    <= r_worst_cost;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= epwr_pkg::S_IDLE;
            r_cap        <= epwr_pkg::CAP_RESET;
            r_count      <= '0;
            r_worst_idx  <= '0;
            r_worst_cost <= '0;
            r_worst_tag  <= '0;
            r_best       <= epwr_pkg::COST_ALL_ONES;
            r_seed       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // The scan starts in the cycle after an admitted offer is stored.
            r_seed <= wr_en;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            // A new result may replace one that leaves in the same cycle.
            if (r_state == epwr_pkg::S_FINISH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                epwr_pkg::S_IDLE: begin
                    if (in_acc) begin
                        if (room) begin
                            r_count <= r_count + CW'(1);
                        end
                        if (room || replace) begin
                            r_state <= epwr_pkg::S_SCAN;
                        end else begin
                            r_state <= epwr_pkg::S_FINISH;
                        end
                    end
                end
                epwr_pkg::S_SCAN: begin
                    if (c_valid[POOL_DEPTH]) begin
                        r_worst_idx  <= c_max_idx[POOL_DEPTH];
                        r_worst_cost <= c_max_cost[POOL_DEPTH];
                        r_worst_tag  <= c_max_tag[POOL_DEPTH];
                        r_best       <= c_min_cost[POOL_DEPTH];
                        r_state      <= epwr_pkg::S_FINISH;
                    end
                end
                epwr_pkg::S_FINISH: begin
                    if (out_free) begin
                        r_state <= epwr_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= epwr_pkg::S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_admitted     = r_o_admitted;
    assign o_written_slot = r_o_slot;
    assign o_evicted      = r_o_evicted;
    assign o_evicted_tag  = r_o_evtag;
    assign o_entry_count  = r_o_count;
    assign o_best_cost    = r_o_best;
    assign o_worst_cost   = r_o_worst;

endmodule

FILE: rtl/core/epwr_cell.sv
`timescale 1ns / 1ps
// ============================================================================
// Elite pool cell
// Holds one pool slot and forwards a running first-maximum / minimum record
// to the next cell, one cell per cycle.
// ============================================================================
module epwr_cell #(
    parameter int POOL_DEPTH = epwr_pkg::POOL_DEPTH_DEF,
    parameter int TAG_BITS   = epwr_pkg::TAG_BITS_DEF,
    parameter int CELL_IDX   = 0,
    localparam int IW        = $clog2(POOL_DEPTH),
    localparam int CW        = $clog2(POOL_DEPTH + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [CW-1:0]               i_count,
    input  logic                        i_wr_en,
    input  logic [IW-1:0]               i_wr_idx,
    input  logic [epwr_pkg::COST_W-1:0] i_wr_cost,
    input  logic [TAG_BITS-1:0]         i_wr_tag,
    input  logic                        i_c_valid,
    input  logic [epwr_pkg::COST_W-1:0] i_c_max_cost,
    input  logic [IW-1:0]               i_c_max_idx,
    input  logic [TAG_BITS-1:0]         i_c_max_tag,
    input  logic [epwr_pkg::COST_W-1:0] i_c_min_cost,
    output logic                        o_c_valid,
    output logic [epwr_pkg::COST_W-1:0] o_c_max_cost,
    output logic [IW-1:0]               o_c_max_idx,
    output logic [TAG_BITS-1:0]         o_c_max_tag,
    output logic [epwr_pkg::COST_W-1:0] o_c_min_cost
);

    logic [epwr_pkg::COST_W-1:0] r_cost;
    logic [TAG_BITS-1:0]         r_tag;
    logic                        r_c_valid;
    logic [epwr_pkg::COST_W-1:0] r_c_max_cost;
    logic [IW-1:0]               r_c_max_idx;
    logic [TAG_BITS-1:0]         r_c_max_tag;
    logic [epwr_pkg::COST_W-1:0] r_c_min_cost;

    logic                        active;
    logic                        take;
    logic [epwr_pkg::COST_W-1:0] n_c_max_cost;
    logic [IW-1:0]               n_c_max_idx;
    logic [TAG_BITS-1:0]         n_c_max_tag;
    logic [epwr_pkg::COST_W-1:0] n_c_min_cost;

    always_comb begin
        active = CW'(CELL_IDX) < i_count;
        // The first slot seeds the record; later slots win only when strictly
        // larger, which keeps the lowest index among equal maxima.
        take   = active && ((CELL_IDX == 0) || (r_cost > i_c_max_cost));
        n_c_max_cost = take ? r_cost : i_c_max_cost;
        n_c_max_idx  = take ? IW'(CELL_IDX) : i_c_max_idx;
        n_c_max_tag  = take ? r_tag : i_c_max_tag;
        n_c_min_cost = (active && (r_cost < i_c_min_cost)) ? r_cost : i_c_min_cost;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_idx == IW'(CELL_IDX))) begin
            r_cost <= i_wr_cost;
            r_tag  <= i_wr_tag;
        end
        r_c_max_cost <= n_c_max_cost;
        r_c_max_idx  <= n_c_max_idx;
        r_c_max_tag  <= n_c_max_tag;
        r_c_min_cost <= n_c_min_cost;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= i_c_valid;
        end
    end

    assign o_c_valid    = r_c_valid;
    assign o_c_max_cost = r_c_max_cost;
    assign o_c_max_idx  = r_c_max_idx;
    assign o_c_max_tag  = r_c_max_tag;
    assign o_c_min_cost = r_c_min_cost;

endmodule
